FILE: rtl/swish_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swish_pkg
// Shared types, constants and elaboration-time helpers for the swish
// activation unit.
// ----------------------------------------------------------------------------
package swish_pkg;

	localparam int DATA_WIDTH         = 16;
	localparam int FRAC_BITS          = DATA_WIDTH - 4;
	localparam int SIG_W              = 16;                  // sigmoid, unsigned Q0.16
	localparam int DEF_TABLE_SEGMENTS = 256;
	localparam logic [63:0] Q62_ONE   = 64'h4000_0000_0000_0000;

	typedef enum logic {
		OP_FWD = 1'b0,
		OP_BWD = 1'b1
	} op_t;

	typedef struct packed {
		op_t                          op;
		logic signed [DATA_WIDTH-1:0] x;
		logic signed [DATA_WIDTH-1:0] fwd_out;
		logic signed [DATA_WIDTH-1:0] grad_in;
	} swish_in_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] result;
		logic                         saturated;
	} swish_out_t;

	// restoring division, elaboration use only
	function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int k = 63; k >= 0; k--) begin
			r = {r[63:0], a[k]};
			if (r >= {1'b0, b}) begin
				r = r - {1'b0, b};
				q[k] = 1'b1;
			end
		end
		return q;
	endfunction

	// (a * b) >> 62, full product kept
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[125:62];
	endfunction

	// round(65536 / (1 + e)), e in Q62
	function automatic logic [16:0] sig_entry(input logic [63:0] e);
		logic [63:0] d;
		logic [63:0] r;
		logic [17:0] q;
		logic [18:0] qr;
		d = Q62_ONE + e;
		r = Q62_ONE;
		q = '0;
		for (int n = 0; n < 18; n++) begin
			q = {q[16:0], 1'b0};
			if (r >= d) begin
				r = r - d;
				q[0] = 1'b1;
			end
			r = {r[62:0], 1'b0};
		end
		qr = {1'b0, q} + 19'd1;
		return qr[17:1];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/swish_activation_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swish_activation_unit
// Elementwise swish, forward (x * sigmoid(x)) and backward gradient, Q4.12.
// ----------------------------------------------------------------------------
// Takes one beat per clock while item_ready is high and returns one result
// beat per item, in order. The rate is set by the seven-stage pipeline:
// index scaling, sigmoid ROM lookup, interpolation multiply, sigmoid
// product, gradient sum, final product and the saturating output register.
// The sigmoid ROM holds TABLE_SEGMENTS + 1 breakpoints over [-8, 8] and is
// computed at elaboration, so no fill time follows reset. item_ready is a
// combinational function of res_ready and the stage valids; a bubble in any
// stage is squeezed out under back-pressure.
// ----------------------------------------------------------------------------
module swish_activation_unit #(
	parameter int TABLE_SEGMENTS = swish_pkg::DEF_TABLE_SEGMENTS
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   item_valid,
	output logic                  item_ready,
	input  swish_pkg::swish_in_t  item,
	output logic                  res_valid,
	input  wire                   res_ready,
	output swish_pkg::swish_out_t res
);
	import swish_pkg::*;

	localparam int IW     = $clog2(TABLE_SEGMENTS);
	localparam int AW     = $clog2(TABLE_SEGMENTS + 1);
	localparam int PW     = DATA_WIDTH + IW;
	localparam int OPB_W  = DATA_WIDTH + 1;
	localparam int MUL_W  = SIG_W + 1 + OPB_W;
	localparam int K_W    = MUL_W - SIG_W;
	localparam int PROD_W = K_W + DATA_WIDTH;
	localparam int R_W    = PROD_W - FRAC_BITS;
	localparam logic signed [R_W-1:0] R_MAX = R_W'((1 << (DATA_WIDTH - 1)) - 1);
	localparam logic signed [R_W-1:0] R_MIN = -R_MAX - R_W'(1);

	typedef logic [SIG_W-1:0] rom_t [0:TABLE_SEGMENTS];

	// breakpoints built from exp(-m/SEG) by repeated Q62 multiplication
	function automatic rom_t build_rom();
		rom_t        t;
		logic [63:0] base;
		logic [63:0] term;
		logic [63:0] pw;
		logic [16:0] p;
		int          half;
		int          m;
		base = Q62_ONE;
		term = Q62_ONE;
		half = 8 * TABLE_SEGMENTS;
		for (int n = 1; n < 40 && term != 64'd0; n++) begin
			term = udiv64(term, 64'(TABLE_SEGMENTS) * 64'(n));
			if (n % 2 == 1) begin
				base = base - term;
			end else begin
				base = base + term;
			end
		end
		pw = Q62_ONE;
		// m walks 0..half in blocks of sixteen steps
		for (int mb = 0; mb <= half / 16; mb++) begin
			for (int mi = 0; mi < 16; mi++) begin
				m = mb * 16 + mi;
				if (m <= half) begin
					if (((m + half) & 15) == 0 || (m > 0 && ((half - m) & 15) == 0)) begin
						p = sig_entry(pw);
						if (((m + half) & 15) == 0 && ((m + half) >> 4) <= TABLE_SEGMENTS) begin
							t[(m + half) >> 4] = p[SIG_W-1:0];
						end
						if (m > 0 && ((half - m) & 15) == 0) begin
							t[(half - m) >> 4] = SIG_W'(17'h10000 - p);
						end
					end
					pw = mul_q62(pw, base);
				end
			end
		end
		return t;
	endfunction

	localparam rom_t SIG_ROM = build_rom();

	// stage enables, back to front
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	assign en_s7      = !res_valid || res_ready;
	assign en_s6      = !vld_s6 || en_s7;
	assign en_s5      = !vld_s5 || en_s6;
	assign en_s4      = !vld_s4 || en_s5;
	assign en_s3      = !vld_s3 || en_s4;
	assign en_s2      = !vld_s2 || en_s3;
	assign en_s1      = !vld_s1 || en_s2;
	assign item_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= item_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) res_valid <= vld_s6;
		end
	end

	// stage 1: scale the offset input to table index and fraction
	logic [DATA_WIDTH-1:0] u_d;
	logic [PW-1:0]         p_d;
	op_t                          op_s1;
	logic signed [DATA_WIDTH-1:0] x_s1, y_s1, dy_s1;
	logic [IW-1:0]                idx_s1;
	logic [DATA_WIDTH-1:0]        frac_s1;

	assign u_d = {~item.x[DATA_WIDTH-1], item.x[DATA_WIDTH-2:0]};
	assign p_d = PW'(u_d) * PW'(TABLE_SEGMENTS);

	always_ff @(posedge clk) begin
		if (en_s1 && item_valid) begin
			op_s1   <= item.op;
			x_s1    <= item.x;
			y_s1    <= item.fwd_out;
			dy_s1   <= item.grad_in;
			idx_s1  <= p_d[PW-1:DATA_WIDTH];
			frac_s1 <= p_d[DATA_WIDTH-1:0];
		end
	end

	// stage 2: ROM lookup of both breakpoints
	logic [AW-1:0]    lo_addr, hi_addr;
	logic [SIG_W-1:0] lo_d, hi_d;
	op_t                          op_s2;
	logic signed [DATA_WIDTH-1:0] x_s2, y_s2, dy_s2;
	logic [SIG_W-1:0]             lo_s2, diff_s2;
	logic [DATA_WIDTH-1:0]        frac_s2;

	assign lo_addr = AW'(idx_s1);
	assign hi_addr = AW'(idx_s1) + AW'(1);
	assign lo_d    = SIG_ROM[lo_addr];
	assign hi_d    = SIG_ROM[hi_addr];

	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			op_s2   <= op_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			dy_s2   <= dy_s1;
			lo_s2   <= lo_d;
			diff_s2 <= (hi_d < lo_d) ? '0 : hi_d - lo_d;
			frac_s2 <= frac_s1;
		end
	end

	// stage 3: interpolate, truncating
	logic [SIG_W+DATA_WIDTH-1:0] interp_d;
	op_t                          op_s3;
	logic signed [DATA_WIDTH-1:0] x_s3, y_s3, dy_s3;
	logic [SIG_W-1:0]             sig_s3;

	assign interp_d = (SIG_W + DATA_WIDTH)'(diff_s2) * (SIG_W + DATA_WIDTH)'(frac_s2);

	always_ff @(posedge clk) begin
		if (en_s3 && vld_s2) begin
			op_s3  <= op_s2;
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			dy_s3  <= dy_s2;
			sig_s3 <= lo_s2 + interp_d[SIG_W+DATA_WIDTH-1:DATA_WIDTH];
		end
	end

	// stage 4: s * x (forward) or s * (1 - y) (backward)
	logic signed [OPB_W-1:0] opb_d;
	logic signed [SIG_W:0]   sig_sx;
	op_t                          op_s4;
	logic signed [DATA_WIDTH-1:0] y_s4, dy_s4;
	logic signed [MUL_W-1:0]      mul_s4;

	assign sig_sx = $signed({1'b0, sig_s3});
	assign opb_d  = (op_s3 == OP_FWD) ? OPB_W'(x_s3)
	                                  : OPB_W'(1 << FRAC_BITS) - OPB_W'(y_s3);

	always_ff @(posedge clk) begin
		if (en_s4 && vld_s3) begin
			op_s4  <= op_s3;
			y_s4   <= y_s3;
			dy_s4  <= dy_s3;
			mul_s4 <= MUL_W'(sig_sx) * MUL_W'(opb_d);
		end
	end

	// stage 5: floor by 2^16, plus y for the gradient factor
	logic signed [K_W-1:0] k_d;
	op_t                          op_s5;
	logic signed [DATA_WIDTH-1:0] dy_s5;
	logic signed [K_W-1:0]        k_s5;

	assign k_d = $signed(mul_s4[MUL_W-1:SIG_W]) + ((op_s4 == OP_FWD) ? K_W'(0) : K_W'(y_s4));

	always_ff @(posedge clk) begin
		if (en_s5 && vld_s4) begin
			op_s5 <= op_s4;
			dy_s5 <= dy_s4;
			k_s5  <= k_d;
		end
	end

	// stage 6: dy * k; forward scales by one so stage 7 stays common
	logic signed [DATA_WIDTH-1:0] mb_d;
	logic signed [PROD_W-1:0]     prod_s6;

	assign mb_d = (op_s5 == OP_FWD) ? DATA_WIDTH'(1 << FRAC_BITS) : dy_s5;

	always_ff @(posedge clk) begin
		if (en_s6 && vld_s5) begin
			prod_s6 <= PROD_W'(k_s5) * PROD_W'(mb_d);
		end
	end

	// stage 7: floor by 2^FRAC_BITS and saturate
	logic signed [R_W-1:0] r_d;
	swish_out_t            res_s7;

	assign r_d = $signed(prod_s6[PROD_W-1:FRAC_BITS]);

	always_ff @(posedge clk) begin
		if (en_s7 && vld_s6) begin
			if (r_d > R_MAX) begin
				res_s7.result    <= DATA_WIDTH'(R_MAX);
				res_s7.saturated <= 1'b1;
			end else if (r_d < R_MIN) begin
				res_s7.result    <= DATA_WIDTH'(R_MIN);
				res_s7.saturated <= 1'b1;
			end else begin
				res_s7.result    <= DATA_WIDTH'(r_d);
				res_s7.saturated <= 1'b0;
			end
		end
	end

	assign res = res_s7;

	// a stall anywhere must trace back to a stalled output beat
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (res_valid && !res_ready))
		else $error("input stalled without output back-pressure");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> vld_s1)
		else $error("accepted beat missing from first stage");

	a_s6_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s6 && !en_s7) |=> (vld_s6 && $stable(prod_s6)))
		else $error("stalled product lost or changed");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s6 && en_s7) |=> res_valid)
		else $error("product not moved to output register");

endmodule
`default_nettype wire

FILE: tb/tb_swish_activation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_swish_activation_unit
// Self-checking bench for the swish forward/backward unit.
// ----------------------------------------------------------------------------
// Every accepted input beat is run through a bit-exact swish predictor: an
// interpolated sigmoid table that the bench builds itself, the forward product
// and the backward gradient, and the final clip. The prediction is queued.
// Each output beat is checked in order against that queue. The tests are
// directed corner beats, a long random stream and a stop-and-drain phase.
// Both handshakes are throttled at random the whole time.
// ----------------------------------------------------------------------------
module tb_swish_activation_unit;
	import swish_pkg::*;

	localparam int TABLE_SEGMENTS = DEF_TABLE_SEGMENTS;
	localparam int QUIET_LIMIT    = 2000;
	localparam int RANDOM_BEATS   = 1200;
	localparam int TAIL_CYCLES    = 20;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_HOLD
	} rx_mode_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	swish_in_t  item       = '0;
	logic       res_valid;
	logic       res_ready  = 1'b0;
	swish_out_t res;

	logic [16:0] sigmoid_lut [0:TABLE_SEGMENTS];
	swish_out_t  pending_results [$];
	swish_out_t  want;

	int       errors       = 0;
	int       checked      = 0;
	int       clipped      = 0;
	int       fwd_sent     = 0;
	int       bwd_sent     = 0;
	int       burst_left   = 0;
	int       quiet_cycles = 0;
	int       rx_left      = 0;
	rx_mode_t rx_mode      = RX_OPEN;

	swish_activation_unit #(
		.TABLE_SEGMENTS(TABLE_SEGMENTS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always #10 clk = ~clk;

	// sigmoid breakpoints, unsigned Q0.16: exp(-|x|) is stepped in Q62 one
	// 1/TABLE_SEGMENTS at a time, and every 16th step lands on a breakpoint
	function automatic void fill_sigmoid_lut();
		logic [63:0]  decay, term, pw, den, rem;
		logic [127:0] prod;
		logic [17:0]  quo;
		logic [18:0]  rounded;
		logic [16:0]  entry;
		int n, m, b, half_span;
		half_span = 8 * TABLE_SEGMENTS;
		decay = Q62_ONE;
		term  = Q62_ONE;
		for (n = 1; n < 40 && term != 0; n++) begin
			term  = term / 64'(TABLE_SEGMENTS * n);
			decay = (n % 2) ? decay - term : decay + term;
		end
		pw = Q62_ONE;
		for (m = 0; m <= half_span; m++) begin
			// round(2^16 / (1 + pw)) by restoring division
			den = Q62_ONE + pw;
			rem = Q62_ONE;
			quo = '0;
			for (b = 0; b < 18; b++) begin
				quo = {quo[16:0], 1'b0};
				if (rem >= den) begin
					rem    = rem - den;
					quo[0] = 1'b1;
				end
				rem = {rem[62:0], 1'b0};
			end
			rounded = 19'(quo) + 19'd1;
			entry   = rounded[17:1];
			if (((m + half_span) % 16) == 0 && ((m + half_span) / 16) <= TABLE_SEGMENTS)
				sigmoid_lut[(m + half_span) / 16] = entry;
			if (m > 0 && ((half_span - m) % 16) == 0)
				sigmoid_lut[(half_span - m) / 16] = 17'h10000 - entry;
			prod = {64'd0, pw} * {64'd0, decay};
			pw   = prod[125:62];
		end
	endfunction

	function automatic logic [16:0] sigmoid_interp(input logic signed [DATA_WIDTH-1:0] xin);
		logic [DATA_WIDTH-1:0] biased;
		logic [31:0]           scaled;
		logic [DATA_WIDTH-1:0] frac;
		logic [16:0]           lo, hi;
		logic [33:0]           span;
		int                    idx;
		biased = xin ^ 16'h8000;
		scaled = 32'(biased) * TABLE_SEGMENTS;
		idx    = int'(scaled >> DATA_WIDTH);
		if (idx >= TABLE_SEGMENTS)
			idx = TABLE_SEGMENTS - 1;
		frac = scaled[DATA_WIDTH-1:0];
		lo   = sigmoid_lut[idx];
		hi   = sigmoid_lut[idx + 1];
		if (hi < lo)
			hi = lo;
		span = 34'(hi - lo) * 34'(frac);
		return lo + 17'(span >> DATA_WIDTH);
	endfunction

	// at 16 bits |dy * k| stays far below 2^62, so the product is never huge
	function automatic swish_out_t compute_swish(input swish_in_t beat);
		swish_out_t outcome;
		longint     x, s, y, dy, k, r;
		x  = $signed(beat.x);
		y  = $signed(beat.fwd_out);
		dy = $signed(beat.grad_in);
		s  = longint'(sigmoid_interp(beat.x));
		if (beat.op == OP_FWD) begin
			r = (x * s) >>> 16;
		end else begin
			k = (y * 65536 + s * ((longint'(1) << FRAC_BITS) - y)) >>> 16;
			r = (dy * k) >>> FRAC_BITS;
		end
		outcome.saturated = 1'b1;
		if (r > 32767)
			r = 32767;
		else if (r < -32768)
			r = -32768;
		else
			outcome.saturated = 1'b0;
		outcome.result = r[DATA_WIDTH-1:0];
		return outcome;
	endfunction

	function automatic swish_in_t make_beat(input op_t op, input logic [15:0] x,
			input logic [15:0] y, input logic [15:0] dy);
		swish_in_t beat;
		beat.op      = op;
		beat.x       = x;
		beat.fwd_out = y;
		beat.grad_in = dy;
		return beat;
	endfunction

	task automatic send_beat(input swish_in_t beat);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		item       <= beat;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		pending_results.push_back(compute_swish(beat));
		if (beat.op == OP_FWD)
			fwd_sent++;
		else
			bwd_sent++;
	endtask

	task automatic wait_for_drain();
		item_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// forward ignores fwd_out and grad_in, so those carry junk here
	task automatic test_forward_extremes();
		logic [15:0] xs [8];
		xs = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h1000, 16'hf000, 16'h0100};
		foreach (xs[i])
			send_beat(make_beat(OP_FWD, xs[i], 16'($urandom), (i % 2) ? 16'h8000 : 16'h7fff));
	endtask

	task automatic test_backward_extremes();
		send_beat(make_beat(OP_BWD, 16'h7fff, 16'h7fff, 16'h7fff));
		send_beat(make_beat(OP_BWD, 16'h8000, 16'h7fff, 16'h7fff));   // clips high
		send_beat(make_beat(OP_BWD, 16'h8000, 16'h7fff, 16'h8000));   // clips low
		send_beat(make_beat(OP_BWD, 16'h8000, 16'h8000, 16'h7fff));   // clips low
		send_beat(make_beat(OP_BWD, 16'h8000, 16'h8000, 16'h8000));   // clips high
		send_beat(make_beat(OP_BWD, 16'h0000, 16'h0000, 16'h1000));
		send_beat(make_beat(OP_BWD, 16'h0000, 16'h1000, 16'hf000));
		send_beat(make_beat(OP_BWD, 16'h7fff, 16'h8000, 16'h0001));
		send_beat(make_beat(OP_BWD, 16'h1000, 16'h0bb0, 16'h0000));
		send_beat(make_beat(OP_BWD, 16'hffff, 16'hffff, 16'hffff));
		send_beat(make_beat(OP_BWD, 16'h0100, 16'h0000, 16'h8000));
	endtask

	task automatic test_random_stream();
		swish_in_t beat;
		int        shape;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			shape = $urandom_range(0, 9);
			beat  = make_beat(op_t'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
				16'($urandom));
			if (shape >= 4 && shape < 8) begin
				// realistic training values: y really is the forward output of x
				beat.x       = 16'(int'($urandom_range(0, 24576)) - 12288);
				beat.fwd_out = compute_swish(make_beat(OP_FWD, beat.x, '0, '0)).result;
				beat.grad_in = 16'(int'($urandom_range(0, 8192)) - 4096);
			end else if (shape >= 8) begin
				// x right on a breakpoint or just below the next one
				beat.x[7:0] = (shape == 8) ? 8'h00 : 8'hff;
			end
			send_beat(beat);
			if (n % 400 == 399)
				wait_for_drain();
		end
	endtask

	task automatic test_drain_pause();
		repeat (3) begin
			repeat ($urandom_range(1, 20))
				send_beat(make_beat(op_t'($urandom_range(0, 1)), 16'($urandom),
					16'($urandom), 16'($urandom)));
			wait_for_drain();
		end
	endtask

	// sink throttling: open, coin flip, one in four, or held off
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(8, 64);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_OPEN:   res_ready <= 1'b1;
			RX_COIN:   res_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: res_ready <= ($urandom_range(0, 3) == 0);
			default:   res_ready <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing pending: result %h saturated %b",
					$time, res.result, res.saturated);
				errors++;
			end else begin
				want = pending_results.pop_front();
				checked++;
				if (res.result !== want.result) begin
					$display("%0t: result mismatch: expected %h, actual %h",
						$time, want.result, res.result);
					errors++;
				end
				if (res.saturated !== want.saturated) begin
					$display("%0t: saturated mismatch: expected %b, actual %b",
						$time, want.saturated, res.saturated);
					errors++;
				end
				if (want.saturated)
					clipped++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (res_valid && res_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles, %0d results outstanding",
					$time, quiet_cycles, pending_results.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		fill_sigmoid_lut();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_forward_extremes();
		test_backward_extremes();
		test_random_stream();
		test_drain_pause();
		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("swish run: %0d forward and %0d backward beats sent, %0d results checked",
			fwd_sent, bwd_sent, checked);
		$display("  %0d clipped results seen, %0d errors", clipped, errors);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
